// File: src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared constants and types for the bipartite graph check block.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  // Default sizes
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;

  // Field widths
  localparam int VTX_W   = 10;
  localparam int EDGE_W  = 2 * VTX_W;
  localparam int COUNT_W = 11;
  localparam int ERR_W   = 2;

  // Item function codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Walker status back to the top level
  typedef struct packed {
    logic done;
    logic bipartite;
  } walk_stat_t;

endpackage

`default_nettype wire

// File: src/bgc_edge_mem.sv
// ----------------------------------------------------------------------------
// bgc_edge_mem
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_edge_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [bgc_pkg::EDGE_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [bgc_pkg::EDGE_W-1:0] rdata
);
  import bgc_pkg::*;

  logic [EDGE_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bgc_walker.sv
// ----------------------------------------------------------------------------
// bgc_walker
// Depth-first two-coloring over the edge store, with mark and stack memories.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_walker #(
  parameter int MAX_VERTICES = 1024,
  parameter int VA_W         = 10,
  parameter int EA_W         = 12,
  parameter int ET_W         = 13
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bgc_pkg::COUNT_W-1:0] n,
  input  wire logic [ET_W-1:0]             edge_total,
  output logic      [EA_W-1:0]             edge_raddr,
  input  wire logic [bgc_pkg::EDGE_W-1:0]  edge_rdata,
  output bgc_pkg::walk_stat_t              stat
);
  import bgc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_CLEAR     = 11'b00000000010,
    S_ROOT      = 11'b00000000100,
    S_ROOT_CHK  = 11'b00000001000,
    S_POP       = 11'b00000010000,
    S_POP_WAIT  = 11'b00000100000,
    S_U_WAIT    = 11'b00001000000,
    S_EDGE      = 11'b00010000000,
    S_EDGE_WAIT = 11'b00100000000,
    S_W_WAIT    = 11'b01000000000,
    S_DONE      = 11'b10000000000
  } state_t;

  // Marks: bit 1 visited, bit 0 color
  logic [1:0]       mark_mem [MAX_VERTICES];
  logic [VTX_W-1:0] stack_mem [MAX_VERTICES];

  state_t             state, state_next;
  logic [COUNT_W-1:0] root, root_next;
  logic [VA_W:0]      clr, clr_next;
  logic [VA_W:0]      depth, depth_next;
  logic [VTX_W-1:0]   u, u_next;
  logic               ucol, ucol_next;
  logic [ET_W-1:0]    e, e_next;
  logic [VTX_W-1:0]   w, w_next;
  logic               bip, bip_next;

  logic             mark_we;
  logic [VA_W-1:0]  mark_waddr, mark_raddr;
  logic [1:0]       mark_wdata, mark_rdata;
  logic             st_we;
  logic [VA_W-1:0]  st_waddr, st_raddr;
  logic [VTX_W-1:0] st_wdata, st_rdata;

  logic [VTX_W-1:0] ea, eb;

  assign ea = edge_rdata[VTX_W-1:0];
  assign eb = edge_rdata[EDGE_W-1:VTX_W];
  assign edge_raddr = e[EA_W-1:0];

  // Walk sequencer
  always_comb begin
    state_next = state;
    root_next  = root;
    clr_next   = clr;
    depth_next = depth;
    u_next     = u;
    ucol_next  = ucol;
    e_next     = e;
    w_next     = w;
    bip_next   = bip;
    mark_we    = 1'b0;
    mark_waddr = VA_W'(w);
    mark_wdata = {1'b1, ~ucol};
    mark_raddr = VA_W'(w);
    st_we      = 1'b0;
    st_waddr   = depth[VA_W-1:0];
    st_wdata   = w;
    st_raddr   = VA_W'(depth - 1'b1);
    stat.done      = 1'b0;
    stat.bipartite = bip;
    case (state)
      S_IDLE: begin
        if (start) begin
          clr_next   = '0;
          bip_next   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr[VA_W-1:0];
        mark_wdata = 2'b00;
        clr_next   = clr + 1'b1;
        if (clr == (VA_W+1)'(MAX_VERTICES - 1)) begin
          root_next  = '0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        mark_raddr = VA_W'(root);
        if (root >= n) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ROOT_CHK;
        end
      end
      S_ROOT_CHK: begin
        if (mark_rdata[1]) begin
          root_next  = root + 1'b1;
          state_next = S_ROOT;
        end else begin
          // Color the root 0 and push it
          mark_we    = 1'b1;
          mark_waddr = VA_W'(root);
          mark_wdata = 2'b10;
          st_we      = 1'b1;
          st_waddr   = '0;
          st_wdata   = VTX_W'(root);
          depth_next = (VA_W+1)'(1);
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (depth == '0) begin
          root_next  = root + 1'b1;
          state_next = S_ROOT;
        end else begin
          depth_next = depth - 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        u_next     = st_rdata;
        mark_raddr = VA_W'(st_rdata);
        state_next = S_U_WAIT;
      end
      S_U_WAIT: begin
        ucol_next  = mark_rdata[0];
        e_next     = '0;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        if (e == edge_total) begin
          state_next = S_POP;
        end else begin
          state_next = S_EDGE_WAIT;
        end
      end
      S_EDGE_WAIT: begin
        // Skip edges out of range or not touching u
        if ((COUNT_W'(ea) >= n) || (COUNT_W'(eb) >= n)) begin
          e_next     = e + 1'b1;
          state_next = S_EDGE;
        end else if (ea == u) begin
          w_next     = eb;
          mark_raddr = VA_W'(eb);
          state_next = S_W_WAIT;
        end else if (eb == u) begin
          w_next     = ea;
          mark_raddr = VA_W'(ea);
          state_next = S_W_WAIT;
        end else begin
          e_next     = e + 1'b1;
          state_next = S_EDGE;
        end
      end
      S_W_WAIT: begin
        if (!mark_rdata[1]) begin
          mark_we    = 1'b1;
          st_we      = 1'b1;
          depth_next = depth + 1'b1;
          e_next     = e + 1'b1;
          state_next = S_EDGE;
        end else if (mark_rdata[0] == ucol) begin
          bip_next   = 1'b0;
          state_next = S_DONE;
        end else begin
          e_next     = e + 1'b1;
          state_next = S_EDGE;
        end
      end
      S_DONE: begin
        stat.done  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bip   <= 1'b1;
    end else begin
      state <= state_next;
      bip   <= bip_next;
    end
    root  <= root_next;
    clr   <= clr_next;
    depth <= depth_next;
    u     <= u_next;
    ucol  <= ucol_next;
    e     <= e_next;
    w     <= w_next;
  end

  // Mark memory
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rdata <= mark_mem[mark_raddr];
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    st_rdata <= stack_mem[st_raddr];
  end

endmodule

`default_nettype wire

// File: src/bipartite_graph_check.sv
// ----------------------------------------------------------------------------
// bipartite_graph_check
// Loads graph edges and reports whether the graph is two-colorable.
// ----------------------------------------------------------------------------
// An add-edge item is taken every cycle while no walk is running and gives no
// result. An evaluate item holds the input while the walker clears the vertex
// marks, tries each vertex in turn as a root, takes vertices off the walk
// stack and, for every popped vertex, scans the whole edge store through its
// single read port. It gives one result and empties the store.
`default_nettype none

module bipartite_graph_check #(
  parameter int MAX_VERTICES = bgc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bgc_pkg::MAX_EDGES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bgc_pkg::COUNT_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        func,
  input  wire logic [bgc_pkg::VTX_W-1:0]   end_a,
  input  wire logic [bgc_pkg::VTX_W-1:0]   end_b,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             is_bipartite,
  output logic [bgc_pkg::ERR_W-1:0]        error_code
);
  import bgc_pkg::*;

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W = $clog2(MAX_EDGES + 1);
  localparam int CAP  = (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;

  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] n;
  logic [ET_W-1:0]    edge_total;
  logic [ERR_W-1:0]   error_latch;
  logic               busy;
  logic               in_acc, add_acc, eval_acc, range_bad, full, edge_we;
  logic [EA_W-1:0]    edge_raddr;
  logic [EDGE_W-1:0]  edge_rdata;
  walk_stat_t         walk_stat;

  assign n = (vertex_count > COUNT_W'(CAP)) ? COUNT_W'(CAP) : vertex_count;

  // Input handshake
  assign in_stall  = busy | (out_valid & (func == FUNC_EVAL));
  assign in_acc    = in_valid & ~in_stall;
  assign add_acc   = in_acc & (func == FUNC_ADD);
  assign eval_acc  = in_acc & (func == FUNC_EVAL);
  assign range_bad = (COUNT_W'(end_a) >= n) || (COUNT_W'(end_b) >= n);
  assign full      = (edge_total == ET_W'(MAX_EDGES));
  assign edge_we   = add_acc & ~range_bad & ~full;

  bgc_edge_mem #(
    .DEPTH  (MAX_EDGES),
    .ADDR_W (EA_W)
  ) u_edge_mem (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total[EA_W-1:0]),
    .wdata ({end_b, end_a}),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  bgc_walker #(
    .MAX_VERTICES (MAX_VERTICES),
    .VA_W         (VA_W),
    .EA_W         (EA_W),
    .ET_W         (ET_W)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .start      (eval_acc),
    .n          (n),
    .edge_total (edge_total),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .stat       (walk_stat)
  );

  // Configuration, edge count, error latch, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      edge_total   <= '0;
      error_latch  <= ERR_NONE;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (add_acc) begin
        if (range_bad) begin
          if (error_latch == ERR_NONE) error_latch <= ERR_RANGE;
        end else if (full) begin
          if (error_latch == ERR_NONE) error_latch <= ERR_FULL;
        end else begin
          edge_total <= edge_total + 1'b1;
        end
      end
      if (eval_acc) begin
        busy <= 1'b1;
      end
      if (walk_stat.done) begin
        busy        <= 1'b0;
        out_valid   <= 1'b1;
        edge_total  <= '0;
        error_latch <= ERR_NONE;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (walk_stat.done) begin
      is_bipartite <= walk_stat.bipartite;
      error_code   <= error_latch;
    end
  end

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    walk_stat.done |-> !out_valid) else $error("result register busy at walk end");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("item accepted during walk");
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    eval_acc |=> busy) else $error("evaluate did not start walk");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    edge_total <= ET_W'(MAX_EDGES)) else $error("edge count past capacity");

endmodule

`default_nettype wire

// File: dv/bipartite_graph_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bipartite_graph_check_tb
// Loads small graphs edge by edge, evaluates them and checks each report
// against a two-coloring predictor kept in the testbench, under random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------

module bipartite_graph_check_tb;
  import bgc_pkg::*;

  localparam int NV         = MAX_VERTICES_DEF;
  localparam int NE         = MAX_EDGES_DEF;
  localparam int TAIL       = 40;
  localparam longint LIMIT  = 6000000;

  typedef struct {
    logic             fn;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
  } graph_item_t;

  typedef struct {
    logic             bip;
    logic [ERR_W-1:0] err;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = FUNC_ADD;
  logic [VTX_W-1:0]     end_a = '0;
  logic [VTX_W-1:0]     end_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 is_bipartite;
  logic [ERR_W-1:0]     error_code;

  bipartite_graph_check dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .end_a(end_a), .end_b(end_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_bipartite(is_bipartite), .error_code(error_code)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [VTX_W-1:0]   store_a [NE];
  logic [VTX_W-1:0]   store_b [NE];
  int                 stored_edges = 0;
  logic [ERR_W-1:0]   err_latch = ERR_NONE;
  int                 vtx_limit = 0;

  graph_item_t        pending_items[$];
  report_t            reports_due[$];
  int                 fail_count = 0;
  int                 reports_seen = 0;
  int                 items_taken = 0;
  int                 graphs_with_error = 0;
  bit                 no_idle = 0;
  bit                 hold_toggle = 0;
  longint             cycle_count = 0;

  // Two-color the stored graph by depth-first walk
  function automatic logic colorable();
    bit   seen [NV];
    bit   shade [NV];
    int   stack [NV];
    int   depth;
    int   u;
    int   w;
    int   ea;
    int   eb;
    for (int v = 0; v < NV; v++) begin
      seen[v] = 0;
      shade[v] = 0;
    end
    for (int root = 0; root < vtx_limit; root++) begin
      if (seen[root]) continue;
      seen[root] = 1;
      shade[root] = 0;
      depth = 0;
      stack[depth++] = root;
      while (depth > 0) begin
        u = stack[--depth];
        for (int e = 0; e < stored_edges; e++) begin
          ea = store_a[e];
          eb = store_b[e];
          if (ea >= vtx_limit || eb >= vtx_limit) continue;
          if (ea == u) w = eb;
          else if (eb == u) w = ea;
          else continue;
          if (!seen[w]) begin
            seen[w] = 1;
            shade[w] = ~shade[u];
            if (depth < NV) stack[depth++] = w;
          end else if (shade[w] == shade[u]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Predict the effect of one item and queue it for the driver
  task automatic send(input logic fn, input int a, input int b);
    graph_item_t it;
    report_t     r;
    it.fn = fn;
    it.a  = a[VTX_W-1:0];
    it.b  = b[VTX_W-1:0];
    if (fn == FUNC_ADD) begin
      if (it.a >= vtx_limit || it.b >= vtx_limit) begin
        if (err_latch == ERR_NONE) err_latch = ERR_RANGE;
      end else if (stored_edges >= NE) begin
        if (err_latch == ERR_NONE) err_latch = ERR_FULL;
      end else begin
        store_a[stored_edges] = it.a;
        store_b[stored_edges] = it.b;
        stored_edges++;
      end
    end else begin
      r.bip = colorable();
      r.err = err_latch;
      if (err_latch != ERR_NONE) graphs_with_error++;
      reports_due.push_back(r);
      stored_edges = 0;
      err_latch = ERR_NONE;
    end
    pending_items.push_back(it);
  endtask

  // Wait until every item is taken and every report has come back
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_count(input int n);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n[COUNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    vtx_limit = (n > NV) ? NV : n;
  endtask

  // Handshake flags seen at the rising edge
  logic item_taken = 1'b0;
  logic report_taken = 1'b0;
  always @(posedge clk) begin
    item_taken   <= !rst && in_valid && !in_stall;
    report_taken <= !rst && out_valid && !out_stall;
    if (!rst && in_valid && !in_stall) items_taken++;
  end

  // Driver: present the next item after a random gap
  int send_gap = 0;
  always @(negedge clk) begin
    graph_item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        cur = pending_items.pop_front();
        func     <= cur.fn;
        end_a    <= cur.a;
        end_b    <= cur.b;
        in_valid <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random wait per report, plus a long hold on request
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_seen = 0;
  always @(negedge clk) begin
    int w;
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (report_taken) begin
      w = no_idle ? 0 : $urandom_range(0, 7);
      stall_left <= w;
      out_stall  <= (w != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each report with the oldest prediction
  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (reports_due.size() == 0) begin
        $error("unexpected report: is_bipartite=%0d error_code=%0d",
               is_bipartite, error_code);
        fail_count++;
      end else begin
        exp_r = reports_due.pop_front();
        if (is_bipartite !== exp_r.bip) begin
          $error("is_bipartite: expected %0d, got %0d", exp_r.bip, is_bipartite);
          fail_count++;
        end
        if (error_code !== exp_r.err) begin
          $error("error_code: expected %0d, got %0d", exp_r.err, error_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Random graph with random count: mostly small, a few at the full size
  task automatic random_graph(inout int budget);
    int pick;
    int n;
    int edges;
    int a;
    int b;
    bit two_side;
    pick = $urandom_range(0, 19);
    if (pick < 14) n = $urandom_range(2, 24);
    else if (pick < 15) n = $urandom_range(0, 1);
    else if (pick < 17) n = NV;
    else if (pick < 18) n = 2047;
    else n = $urandom_range(25, 2047);
    no_idle = ($urandom_range(0, 4) == 0);
    write_count(n);
    edges = (vtx_limit > 24) ? $urandom_range(0, 6) : $urandom_range(0, 20);
    two_side = $urandom_range(0, 1);
    for (int e = 0; e < edges; e++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2 || vtx_limit < 2) begin
        a = $urandom_range(0, NV - 1);
        b = $urandom_range(0, NV - 1);
      end else if (pick < 3) begin
        a = $urandom_range(0, vtx_limit - 1);
        b = a;
      end else begin
        a = $urandom_range(0, vtx_limit - 1);
        b = $urandom_range(0, vtx_limit - 1);
        // keep ends on opposite parity for a two-colorable graph
        if (two_side && a[0] == b[0]) b = (b == 0) ? 1 : b - 1;
      end
      send(FUNC_ADD, a, b);
      budget--;
      // shrink the count between load and evaluate now and then
      if (e == edges - 1 && $urandom_range(0, 9) == 0 && vtx_limit > 2)
        write_count($urandom_range(1, vtx_limit - 1));
    end
    send(FUNC_EVAL, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
    budget--;
  endtask

  initial begin
    int budget;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: full range ends, bit patterns, self-loops, odd cycles
    write_count(NV);
    send(FUNC_ADD, 0, 1023);
    send(FUNC_ADD, 1023, 1022);
    send(FUNC_ADD, 682, 341);
    send(FUNC_EVAL, 0, 0);
    send(FUNC_ADD, 5, 5);
    send(FUNC_EVAL, 1023, 1023);
    write_count(3);
    send(FUNC_ADD, 0, 1);
    send(FUNC_ADD, 1, 2);
    send(FUNC_ADD, 2, 0);
    send(FUNC_EVAL, 0, 0);
    send(FUNC_ADD, 0, 3);
    send(FUNC_ADD, 0, 1);
    send(FUNC_EVAL, 0, 0);
    send(FUNC_EVAL, 0, 0);
    write_count(0);
    send(FUNC_ADD, 0, 0);
    send(FUNC_EVAL, 0, 0);
    write_count(4);
    send(FUNC_ADD, 0, 1);
    send(FUNC_ADD, 1, 3);
    send(FUNC_ADD, 3, 0);
    write_count(3);
    send(FUNC_EVAL, 0, 0);
    write_count(2047);
    send(FUNC_ADD, 1023, 1023);
    send(FUNC_EVAL, 0, 0);

    // Fill the edge store, overflow it, then an out-of-range edge
    write_count(2);
    no_idle = 1;
    for (int i = 0; i < NE; i++) send(FUNC_ADD, i % 2, 1 - (i % 2));
    send(FUNC_ADD, 1, 0);
    send(FUNC_ADD, 9, 9);
    send(FUNC_EVAL, 0, 0);
    no_idle = 0;

    // Long receiver hold while the sender keeps loading
    write_count(8);
    send(FUNC_ADD, 0, 1);
    send(FUNC_EVAL, 0, 0);
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 30; i++) send(FUNC_ADD, i % 8, (i + 3) % 8);
    send(FUNC_EVAL, 0, 0);

    // Random graphs
    budget = 850;
    while (budget > 0) random_graph(budget);

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("%0d items taken, %0d graph reports checked, %0d with a latched error",
             items_taken, reports_seen, graphs_with_error);
    $display("counts from 0 to 2047, full and overflowed edge store, long output hold");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: bipartite_graph_check.f
src/bgc_pkg.sv
src/bgc_edge_mem.sv
src/bgc_walker.sv
src/bipartite_graph_check.sv
dv/bipartite_graph_check_tb.sv
